### hdl/asg_pkg.sv
// Shared types and constants for the alternating step generator.
// Used by asg_lfsr_bank, asg_ctrl and alternating_step_prng_top.
package asg_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned CountW = 7;

  localparam logic [WordW-1:0] MASK_CLOCK  = 64'h8000_0000_0000_000D;
  localparam logic [WordW-1:0] MASK_FIRST  = 64'h1000_0000_0000_C001;
  localparam logic [WordW-1:0] MASK_SECOND = 64'h4000_0000_0000_0001;
  localparam logic [WordW-1:0] MIX_CLOCK   = 64'h0000_0000_B8A2_13CD;
  localparam logic [WordW-1:0] MIX_FIRST   = 64'h0000_0000_DA12_3456;
  localparam logic [WordW-1:0] MIX_SECOND  = 64'h0000_0000_ECE6_B896;

  localparam logic [CountW-1:0] MAX_BITS = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } asg_state_t;

  // sequencer to register bank
  typedef struct packed {
    logic reload;
    logic step;
  } asg_cmd_t;

  function automatic logic [WordW-1:0] nonzero_or_one(input logic [WordW-1:0] v);
    nonzero_or_one = (v == '0) ? {{(WordW-1){1'b0}}, 1'b1} : v;
  endfunction

  function automatic logic [WordW-1:0] galois_advance(input logic [WordW-1:0] r,
                                                      input logic [WordW-1:0] taps);
    galois_advance = r[0] ? ((r >> 1) ^ taps) : (r >> 1);
  endfunction

endpackage

### hdl/asg_lfsr_bank.sv
// Three Galois shift registers of the alternating step generator.
// Depends on asg_pkg; steps once per cycle under command of asg_ctrl.
module asg_lfsr_bank
  import asg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  asg_cmd_t         cmd,
  input  logic [WordW-1:0] seed,
  output logic             step_bit
);

  logic [WordW-1:0] clock_lfsr, first_lfsr, second_lfsr;
  logic [WordW-1:0] clock_next, first_next, second_next;

  always_comb begin
    clock_next  = galois_advance(clock_lfsr, MASK_CLOCK);
    first_next  = first_lfsr;
    second_next = second_lfsr;
    if (clock_next[0]) begin
      first_next = galois_advance(first_lfsr, MASK_FIRST);
    end else begin
      second_next = galois_advance(second_lfsr, MASK_SECOND);
    end
    step_bit = first_next[0] ^ second_next[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // reset loads the mix constants, as a reload with a zero seed would
      clock_lfsr  <= nonzero_or_one(MIX_CLOCK);
      first_lfsr  <= nonzero_or_one(MIX_FIRST);
      second_lfsr <= nonzero_or_one(MIX_SECOND);
    end else if (cmd.reload) begin
      clock_lfsr  <= nonzero_or_one(seed ^ MIX_CLOCK);
      first_lfsr  <= nonzero_or_one(seed ^ MIX_FIRST);
      second_lfsr <= nonzero_or_one(seed ^ MIX_SECOND);
    end else if (cmd.step) begin
      clock_lfsr  <= clock_next;
      first_lfsr  <= first_next;
      second_lfsr <= second_next;
    end
  end

endmodule

### hdl/asg_ctrl.sv
// Sequencer: takes one request word, reloads the register bank or runs it one
// step per cycle gathering bits, and holds the result word. Depends on asg_pkg.
module asg_ctrl
  import asg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              kind,
  input  logic [CountW-1:0] bit_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WordW-1:0]  random_bits,
  input  logic              step_bit,
  output asg_cmd_t          cmd
);

  asg_state_t        state, state_next;
  logic [CountW-1:0] remain, remain_next;
  logic [WordW-1:0]  acc, acc_next;
  logic              load_out;
  logic [CountW-1:0] sat_count;

  assign sat_count = (bit_count > MAX_BITS) ? MAX_BITS : bit_count;

  always_comb begin
    state_next  = state;
    remain_next = remain;
    acc_next    = acc;
    in_ready    = 1'b0;
    load_out    = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          acc_next    = '0;
          remain_next = sat_count;
          if (!kind) begin
            cmd.reload = 1'b1;
            state_next = ST_DONE;
          end else if (sat_count == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd.step    = 1'b1;
        acc_next    = {acc[WordW-2:0], step_bit};
        remain_next = remain - 1'b1;
        if (remain == 7'd1) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    remain <= remain_next;
    acc    <= acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      random_bits <= acc;
    end
  end

endmodule

### hdl/alternating_step_prng_top.sv
// Alternating step generator built from three 64-bit Galois shift registers.
// A generate word of n bits (counts above 64 act as 64) has its result offered
// once the sequencer has run n register steps, one step per cycle in the shift
// register bank, and loaded the output register; a reload word, and a generate
// word of zero bits, take no register steps. One request word is in work at
// a time: in_ready is high only while the sequencer is idle, which it re-enters
// on the edge that loads the result, so no new word is taken before then. A
// finished word waits in the sequencer while the previous result is still held
// by a low out_ready. The seed register is written through the cfg port, which
// is always ready; a new seed takes effect on the next reload word only.
module alternating_step_prng_top
  import asg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              kind,
  input  logic [CountW-1:0] bit_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WordW-1:0]  random_bits,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [WordW-1:0]  seed_value
);

  logic [WordW-1:0] seed;
  logic             step_bit;
  asg_cmd_t         cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_valid && cfg_ready) begin
      seed <= seed_value;
    end
  end

  asg_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .bit_count   (bit_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .random_bits (random_bits),
    .step_bit    (step_bit),
    .cmd         (cmd)
  );

  asg_lfsr_bank u_bank (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .seed     (seed),
    .step_bit (step_bit)
  );

endmodule
